[rtl/snbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snbd_pkg
// Shared types and constants for the spectrum normalizer / beat detector.
// ----------------------------------------------------------------------------
package snbd_pkg;

    localparam int BIN_COUNT = 512;
    localparam int LOW_BINS  = 5;

    localparam int IDX_W  = 9;
    localparam int PART_W = 24;
    localparam int MAG_W  = 24;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 2;
    localparam int SQ_W   = 48;

    localparam logic [ADDR_W-1:0] REG_DECAY  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_FLOOR  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_THRESH = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MANUAL = 2'd3;

    localparam logic [CFG_W-1:0] DECAY_RST  = 16'd21;
    localparam logic [CFG_W-1:0] FLOOR_RST  = 16'd1049;
    localparam logic [CFG_W-1:0] THRESH_RST = 16'd524;

    // floor(n / 10) == (n * RECIP10) >> 35 for any n below 2^32
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam logic [MAG_W-1:0] LEVEL_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SQRT,
        ST_PREP,
        ST_DIV,
        ST_UPD,
        ST_AVG1,
        ST_AVG2,
        ST_BEAT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic trig;
        logic sq_re;
        logic sq_im;
        logic sqrt_step;
        logic div_prep;
        logic div_step;
        logic upd;
        logic avg1;
        logic avg2;
        logic beat;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic div_skip;
        logic div_last;
        logic frame_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/snbd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snbd_ctrl
// Sequencer: one item through square, root, divide, update, avg/beat, output.
// ----------------------------------------------------------------------------
module snbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_command,
    input  snbd_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output snbd_pkg::t_dp_cmd o_cmd
);
    import snbd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_in_command) n_state = ST_SQ_RE;
            end
            ST_SQ_RE: n_state = ST_SQ_IM;
            ST_SQ_IM: n_state = ST_SQRT;
            ST_SQRT: begin
                if (i_stat.sqrt_last) n_state = ST_PREP;
            end
            ST_PREP: n_state = i_stat.div_skip ? ST_UPD : ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_UPD;
            end
            ST_UPD:  n_state = i_stat.frame_last ? ST_AVG1 : ST_OUT;
            ST_AVG1: n_state = ST_AVG2;
            ST_AVG2: n_state = ST_BEAT;
            ST_BEAT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && !i_in_command;
                o_cmd.trig = i_in_valid && i_in_command;
            end
            ST_SQ_RE: o_cmd.sq_re     = 1'b1;
            ST_SQ_IM: o_cmd.sq_im     = 1'b1;
            ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            ST_PREP:  o_cmd.div_prep  = 1'b1;
            ST_DIV:   o_cmd.div_step  = 1'b1;
            ST_UPD:   o_cmd.upd       = 1'b1;
            ST_AVG1:  o_cmd.avg1      = 1'b1;
            ST_AVG2:  o_cmd.avg2      = 1'b1;
            ST_BEAT:  o_cmd.beat      = 1'b1;
            ST_OUT:   o_cmd.out_load  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/snbd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snbd_dp
// Datapath: shared squarer, serial root, serial divider, averages, output reg.
// ----------------------------------------------------------------------------
module snbd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  snbd_pkg::t_dp_cmd             i_cmd,
    output snbd_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [snbd_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  logic [snbd_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [snbd_pkg::IDX_W-1:0]    i_bin_index,
    input  logic signed [snbd_pkg::PART_W-1:0] i_real_part,
    input  logic signed [snbd_pkg::PART_W-1:0] i_imag_part,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [snbd_pkg::MAG_W-1:0]    o_level,
    output logic                          o_frame_end,
    output logic                          o_beat
);
    import snbd_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_decay, r_floor, r_thr;
    logic             r_manual;
    // frame state
    logic [MAG_W-1:0] r_rm, r_peak, r_smooth, r_rapid;
    logic             r_latch;
    // per item working registers
    logic [IDX_W-1:0]         r_idx;
    logic signed [PART_W-1:0] r_re, r_im;
    logic [SQ_W-1:0]          r_acc, r_res, r_bit;
    logic [4:0]               r_cnt;
    logic [MAG_W-1:0]         r_mag, r_rem, r_dsh, r_q;
    logic [59:0]              r_prod;
    logic [39:0]              r_tp;
    logic                     r_beat;
    // output register
    logic                     r_ovalid, r_olast, r_obeat;
    logic [MAG_W-1:0]         r_olevel;

    logic signed [PART_W-1:0] w_sel;
    logic signed [SQ_W-1:0]   w_sq;
    logic [SQ_W-1:0]          w_trial;
    logic [MAG_W:0]           w_rem2, w_rdiff;
    logic                     w_ge;
    logic [MAG_W-1:0]         w_dec, w_newrm, w_mag;
    logic [27:0]              w_n9;
    logic [26:0]              w_n7;
    logic [MAG_W-1:0]         w_diff;
    logic                     w_frame_last, w_low;

    assign w_sel   = i_cmd.sq_re ? r_re : r_im;
    assign w_sq    = w_sel * w_sel;
    assign w_trial = r_res + r_bit;
    assign w_mag   = r_res[MAG_W-1:0];

    assign w_rem2  = {r_rem, r_dsh[MAG_W-1]};
    assign w_ge    = w_rem2 >= {1'b0, r_rm};
    assign w_rdiff = w_rem2 - {1'b0, r_rm};

    assign w_dec   = (r_rm > {8'd0, r_decay}) ? (r_rm - {8'd0, r_decay}) : '0;
    assign w_newrm = (w_dec < {8'd0, r_floor}) ? {8'd0, r_floor} : w_dec;

    assign w_n9 = {1'b0, r_smooth, 3'b0} + {4'd0, r_smooth} + {4'd0, r_peak};
    assign w_n7 = {r_rapid, 3'b0} - {3'd0, r_rapid} + {3'd0, r_peak};
    assign w_diff = r_rapid - r_smooth;

    assign w_frame_last = (32'(r_idx) == 32'(BIN_COUNT - 1));
    assign w_low        = (32'(r_idx) < 32'(LOW_BINS));

    assign o_stat.sqrt_last  = (r_cnt == '0);
    assign o_stat.div_last   = (r_cnt == '0);
    assign o_stat.div_skip   = (r_rm == '0) || ({8'd0, w_mag} >= {r_rm, 8'd0});
    assign o_stat.frame_last = w_frame_last;
    assign o_stat.out_free   = !r_ovalid || i_m_tready;

    // control-bearing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DECAY_RST;
            r_floor  <= FLOOR_RST;
            r_thr    <= THRESH_RST;
            r_manual <= 1'b0;
            r_rm     <= '0;
            r_peak   <= '0;
            r_smooth <= '0;
            r_rapid  <= '0;
            r_latch  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DECAY:  r_decay  <= i_cfg_wdata;
                    REG_FLOOR:  r_floor  <= i_cfg_wdata;
                    REG_THRESH: r_thr    <= i_cfg_wdata;
                    REG_MANUAL: r_manual <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.trig) r_latch <= 1'b1;
            // frame start: decay the maximum, restart the low band search
            if (i_cmd.load && i_bin_index == '0) begin
                r_rm   <= w_newrm;
                r_peak <= '0;
            end
            if (i_cmd.upd) begin
                if (r_mag > r_rm) r_rm <= r_mag;
                if (w_low && r_mag > r_peak) r_peak <= r_mag;
            end
            if (i_cmd.avg1) r_rapid  <= w_n7[26:3];
            if (i_cmd.avg2) r_smooth <= r_prod[58:35];
            if (i_cmd.beat && r_manual) r_latch <= 1'b0;
            if (i_cmd.out_load)        r_ovalid <= 1'b1;
            else if (i_m_tready)       r_ovalid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_bin_index;
            r_re  <= i_real_part;
            r_im  <= i_imag_part;
        end
        if (i_cmd.sq_re) r_acc <= unsigned'(w_sq);
        if (i_cmd.sq_im) begin
            r_acc <= r_acc + unsigned'(w_sq);
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
            r_cnt <= 5'd23;
        end
        if (i_cmd.sqrt_step) begin
            if (r_acc >= w_trial) begin
                r_acc <= r_acc - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_cmd.div_prep) begin
            r_mag <= w_mag;
            // zero max or quotient past 24 bits settle here without dividing
            if (r_rm == '0) r_q <= (w_mag != '0) ? LEVEL_MAX : '0;
            else            r_q <= LEVEL_MAX;
            r_rem <= {8'd0, w_mag[MAG_W-1:8]};
            r_dsh <= {w_mag[7:0], 16'd0};
            r_cnt <= 5'd23;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rdiff[MAG_W-1:0] : w_rem2[MAG_W-1:0];
            r_q   <= {r_q[MAG_W-2:0], w_ge};
            r_dsh <= r_dsh << 1;
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_cmd.avg1) r_prod <= w_n9 * RECIP10;
        if (i_cmd.avg2) r_tp   <= r_thr * r_rm;
        if (i_cmd.beat) begin
            if (r_manual) r_beat <= r_latch;
            else          r_beat <= (r_rapid > r_smooth) && ({w_diff, 16'd0} > r_tp);
        end
        if (i_cmd.out_load) begin
            r_olevel <= r_q;
            r_olast  <= w_frame_last;
            r_obeat  <= w_frame_last && r_beat;
        end
    end

    assign o_m_tvalid  = r_ovalid;
    assign o_level     = r_olevel;
    assign o_frame_end = r_olast;
    assign o_beat      = r_obeat;

endmodule

[rtl/spectrum_normalizer_beat_detector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_normalizer_beat_detector_top
// Bin magnitude over a decaying running maximum, with low-band beat detection.
// ----------------------------------------------------------------------------
// Flow: a bin is accepted only while the sequencer is idle and runs through
//   the square, root, divide and update phases (plus averages and beat on
//   the last bin of a frame) and the output phase before the next item is
//   taken. The serial root and the serial restoring divider each give one
//   bit per cycle; when the level is zero max or saturated the divide is
//   skipped. A trigger item is taken with no result.
// Reset: synchronous, active low; clears the maximum, peak, averages, trigger
//   latch and output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module spectrum_normalizer_beat_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // bin_index[8:0], real_part[32:9], imag_part[56:33]
    input  logic        i_s_tuser,   // command
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // level[23:0]
    output logic        o_m_tlast,   // frame_end
    output logic        o_m_tuser,   // beat
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [snbd_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [snbd_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import snbd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer only: it decides which datapath phase runs each cycle.
    snbd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .i_in_command (i_s_tuser),
        .i_stat       (w_stat),
        .o_in_ready   (o_s_tready),
        .o_cmd        (w_cmd)
    );

    // Arithmetic and state; the output register lets the next item enter
    // while a result still waits downstream.
    snbd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bin_index (i_s_tdata[8:0]),
        .i_real_part (signed'(i_s_tdata[32:9])),
        .i_imag_part (signed'(i_s_tdata[56:33])),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_level     (o_m_tdata),
        .o_frame_end (o_m_tlast),
        .o_beat      (o_m_tuser)
    );

endmodule

[tb/spectrum_normalizer_beat_detector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_normalizer_beat_detector_top_tb
// Self-checking bench: bins and trigger items go in over the input stream,
// normalized levels and beat flags are predicted in the bench and compared
// item by item on the result stream under random bursts and stalls.
// ----------------------------------------------------------------------------
module spectrum_normalizer_beat_detector_top_tb;
    import snbd_pkg::*;

    localparam logic CMD_BIN   = 1'b0;
    localparam logic CMD_TRIG  = 1'b1;
    localparam int  DRAIN_CYC = 200;     // extra wait after the result queue empties
    localparam int  WDOG_MAX  = 20000;   // idle cycles before giving up
    localparam int  N_RAND    = 1900;

    typedef struct packed {
        logic        cmd;
        logic [8:0]  idx;
        logic [23:0] re;
        logic [23:0] im;
    } bin_item_t;

    typedef struct packed {
        logic [23:0] level;
        logic        frame_end;
        logic        beat;
    } level_t;

    // directed row: item plus optional hand-typed expectation
    typedef struct packed {
        bin_item_t   item;
        logic        has_exp;
        level_t      exp;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    always #5 i_clk = ~i_clk;

    spectrum_normalizer_beat_detector_top dut (.*);

    // predictor state
    logic [15:0] p_decay, p_floor, p_thresh;
    logic        p_manual;
    logic [23:0] p_max, p_peak, p_smooth, p_rapid;
    logic        p_trig;

    level_t  exp_levels[$];
    level_t  pinned[$];     // hand-typed expectations awaiting the same slot
    logic    pinned_on[$];
    int      n_err = 0;
    int      wdog = 0;
    bit      use_bursts = 1;

    function automatic logic [23:0] isqrt48(logic [47:0] v);
        logic [47:0] res, bit_w;
        res = 0;
        bit_w = 48'h1 << 46;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w >>= 2;
        end
        return res[23:0];
    endfunction

    // returns 1 if the item yields a result
    function automatic bit predict_level(bin_item_t it, output level_t r);
        longint re, im;
        logic [47:0] sq;
        logic [23:0] mag, m;
        logic [63:0] q, d;
        r = '0;
        if (it.cmd == CMD_TRIG) begin
            p_trig = 1'b1;
            return 0;
        end
        re = longint'($signed(it.re));
        im = longint'($signed(it.im));
        if (it.idx == 0) begin
            m = (p_max > p_decay) ? p_max - p_decay : 24'd0;
            p_max = (m < p_floor) ? 24'(p_floor) : m;
            p_peak = 0;
        end
        sq = 48'(re * re) + 48'(im * im);
        mag = isqrt48(sq);
        if (p_max == 0) begin
            r.level = (mag != 0) ? LEVEL_MAX : 24'd0;
        end else begin
            q = ({40'd0, mag} << 16) / p_max;
            r.level = (q > 64'hFFFFFF) ? LEVEL_MAX : q[23:0];
        end
        if (mag > p_max) p_max = mag;
        if (it.idx < LOW_BINS && mag > p_peak) p_peak = mag;
        if (it.idx == BIN_COUNT - 1) begin
            r.frame_end = 1'b1;
            p_smooth = 24'((64'(p_smooth) * 9 + p_peak) / 10);
            p_rapid  = 24'((64'(p_rapid) * 7 + p_peak) / 8);
            if (p_manual) begin
                r.beat = p_trig;
                p_trig = 1'b0;
            end else if (p_rapid > p_smooth) begin
                d = 64'(p_rapid - p_smooth) << 16;
                r.beat = d > 64'(p_thresh) * p_max;
            end
        end
        return 1;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        level_t got, want, hand;
        logic   hand_on;
        if (o_s_tready && i_s_tvalid) wdog <= 0;
        else if (o_m_tvalid && i_m_tready) wdog <= 0;
        else wdog <= wdog + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata, o_m_tlast, o_m_tuser};
            if (exp_levels.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %p", got);
            end else begin
                want = exp_levels.pop_front();
                hand = pinned.pop_front();
                hand_on = pinned_on.pop_front();
                // beat only means something on the frame end
                if (got.level !== want.level || got.frame_end !== want.frame_end ||
                    (want.frame_end && got.beat !== want.beat) ||
                    (hand_on && got !== hand)) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: expected %p (typed %p) got %p",
                                 want, hand, got);
                end
            end
        end
        if (wdog >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: own stall pattern, with calm stretches
    always @(posedge i_clk) begin
        int ph;
        ph = $urandom_range(0, 99);
        if (!i_rst_n) i_m_tready <= 1'b0;
        else if (($time / 4000) % 3 == 0) i_m_tready <= 1'b1;
        else i_m_tready <= (ph < 65);
    end

    // ---------------- sender ----------------
    task automatic send_item(bin_item_t it, logic has_exp, level_t hand);
        level_t r;
        int gap;
        if (use_bursts && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 70);
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.cmd;
        i_s_tdata  <= {7'd0, it.im, it.re, it.idx};
        do @(posedge i_clk); while (!o_s_tready);
        i_s_tvalid <= 1'b0;
        if (predict_level(it, r)) begin
            exp_levels.push_back(r);
            pinned.push_back(hand);
            pinned_on.push_back(has_exp);
        end
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (exp_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (a)
            REG_DECAY:  p_decay = v;
            REG_FLOOR:  p_floor = v;
            REG_THRESH: p_thresh = v;
            default:    p_manual = v[0];
        endcase
        @(posedge i_clk);
    endtask

    function automatic bin_item_t mk(logic c, int ix, logic [23:0] re, logic [23:0] im);
        bin_item_t it;
        it.cmd = c; it.idx = 9'(ix); it.re = re; it.im = im;
        return it;
    endfunction

    // random part: mostly whole low-band-heavy frames, some noise
    task automatic random_frame(int nbins);
        bin_item_t it;
        int k;
        for (k = 0; k < nbins; k++) begin
            it.cmd = ($urandom_range(0, 30) == 0);
            if (k == 0) it.idx = 0;
            else if (k == nbins - 1) it.idx = BIN_COUNT - 1;
            else if ($urandom_range(0, 9) == 0) it.idx = 9'($urandom);
            else it.idx = 9'($urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: begin it.re = 24'($urandom); it.im = 24'($urandom); end
                1: begin
                    it.re = 24'($signed(12'($urandom)));
                    it.im = 24'($signed(12'($urandom)));
                end
                2: begin it.re = 24'($urandom_range(0, 3000)); it.im = 0; end
                default: begin it.re = 24'($signed(18'($urandom))); it.im = 24'($urandom); end
            endcase
            send_item(it, 1'b0, '0);
        end
    endtask

    row_t dir_rows[$];

    initial begin
        int i, n;
        p_decay = DECAY_RST; p_floor = FLOOR_RST; p_thresh = THRESH_RST;
        p_manual = 0; p_max = 0; p_peak = 0; p_smooth = 0; p_rapid = 0; p_trig = 0;

        // directed table; typed results only where obvious
        dir_rows = '{
            // zero maximum before any frame start: saturates or zero
            '{mk(CMD_BIN, 3, 24'd0, 24'd0), 1'b1, '{24'd0, 1'b0, 1'b0}},
            '{mk(CMD_BIN, 3, 24'd5, 24'd0), 1'b1, '{LEVEL_MAX, 1'b0, 1'b0}},
            // frame start: maximum floored to 1049, tiny bin gives 0
            '{mk(CMD_BIN, 0, 24'd0, 24'd0), 1'b1, '{24'd0, 1'b0, 1'b0}},
            '{mk(CMD_BIN, 1, 24'h800000, 24'h800000), 1'b0, '0},
            '{mk(CMD_BIN, 2, 24'h7FFFFF, 24'h7FFFFF), 1'b0, '0},
            '{mk(CMD_BIN, 4, 24'h7FFFFF, 24'h800000), 1'b0, '0},
            '{mk(CMD_BIN, 5, 24'hFFFFFF, 24'h000001), 1'b0, '0},
            '{mk(CMD_TRIG, 0, 24'h123456, 24'h654321), 1'b0, '0},
            '{mk(CMD_BIN, 511, 24'h000400, 24'hFFFC00), 1'b0, '0},
            // out-of-order bins
            '{mk(CMD_BIN, 300, 24'h0, 24'h7FFFFF), 1'b0, '0},
            '{mk(CMD_BIN, 511, 24'h1, 24'h1), 1'b0, '0},
            '{mk(CMD_BIN, 0, 24'h0, 24'h0), 1'b0, '0},
            '{mk(CMD_BIN, 511, 24'h0, 24'h0), 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].has_exp, dir_rows[k].exp);

        // hold off until the pipe is empty
        wait_idle();

        // manual mode with trigger, extreme registers
        write_reg(REG_MANUAL, 1'b1);
        write_reg(REG_DECAY, 16'hFFFF);
        write_reg(REG_FLOOR, 16'd1);
        write_reg(REG_THRESH, 16'd0);
        send_item(mk(CMD_TRIG, 0, 0, 0), 1'b0, '0);
        send_item(mk(CMD_BIN, 0, 24'd100, 24'd0), 1'b0, '0);
        send_item(mk(CMD_BIN, 511, 24'd100, 24'd0), 1'b0, '0);
        send_item(mk(CMD_BIN, 0, 24'd100, 24'd0), 1'b0, '0);
        send_item(mk(CMD_BIN, 511, 24'd100, 24'd0), 1'b0, '0);
        wait_idle();

        // random phases over several settings
        n = 0;
        for (i = 0; n < N_RAND; i++) begin
            case (i % 5)
                0: begin write_reg(REG_MANUAL, 0); write_reg(REG_THRESH, 16'hFFFF);
                         write_reg(REG_DECAY, 0); write_reg(REG_FLOOR, 16'hFFFF); end
                1: begin write_reg(REG_THRESH, 16'($urandom_range(0, 2000)));
                         write_reg(REG_DECAY, 16'($urandom));
                         write_reg(REG_FLOOR, 16'($urandom_range(1, 65535))); end
                2: begin write_reg(REG_MANUAL, 1); write_reg(REG_THRESH, 0); end
                3: begin write_reg(REG_MANUAL, 0); write_reg(REG_FLOOR, 16'd1);
                         write_reg(REG_DECAY, 16'd21); write_reg(REG_THRESH, 16'd524); end
                default: write_reg(REG_THRESH, 16'($urandom));
            endcase
            use_bursts = (i % 4 != 3);
            repeat (16) begin
                random_frame($urandom_range(3, 12));
            end
            n += 120;
            wait_idle();
        end

        wait_idle();
        if (n_err == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
